/* rtl/kcps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcps_pkg: shared types and constants of the key-controlled sampler
// Beat layouts between the input stage, the tick controller and the
// output stage, plus the widths, key bit positions and fixed scaling constants.
// ----------------------------------------------------------------------------
package kcps_pkg;

    localparam int unsigned RAW_W    = 12;
    localparam int unsigned PROD_W   = 24;
    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned KEYS_W   = 4;

    // Millivolt scaling: raw * 3300 / 4095
    localparam logic [RAW_W-1:0] MV_FULL_SCALE  = 12'd3300;
    localparam logic [RAW_W-1:0] RAW_FULL_SCALE = 12'd4095;

    // Key bit positions inside the key level vector
    localparam int unsigned KEY_TOGGLE = 0;
    localparam int unsigned KEY_P5     = 1;
    localparam int unsigned KEY_P10    = 2;
    localparam int unsigned KEY_P15    = 3;

    // Accepted tick after the input register
    typedef struct packed {
        logic [KEYS_W-1:0]   keys;
        logic [RAW_W-1:0]    raw;
        logic [PROD_W-1:0]   prod;   // raw * 3300
    } t_item;

    // One result beat
    typedef struct packed {
        logic                sampling_on;
        logic                blink_led;
        logic                sample_valid;
        logic [RAW_W-1:0]    sample_raw;
        logic [RAW_W-1:0]    sample_mv;
        logic [PERIOD_W-1:0] period_now;
    } t_result;

endpackage

`default_nettype wire

/* rtl/kcps_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcps_in_reg: input register of the sampler
// Captures one tick beat and starts the millivolt scaling by forming
// raw * 3300 on the way into the register.
// ----------------------------------------------------------------------------
module kcps_in_reg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [kcps_pkg::KEYS_W-1:0]   i_keys,
    input  wire logic [kcps_pkg::RAW_W-1:0]    i_raw,
    input  wire logic                          i_take,
    output logic                               o_valid,
    output kcps_pkg::t_item                    o_item
);
    import kcps_pkg::*;

    logic  r_vld;
    t_item r_item;
    t_item n_item;

    // Accept when empty or when the held beat moves on this cycle
    assign o_ready = !r_vld || i_take;

    // Form the scaled product ahead of the register
    always_comb begin
        n_item.keys = i_keys;
        n_item.raw  = i_raw;
        n_item.prod = PROD_W'(i_raw) * PROD_W'(MV_FULL_SCALE);
    end

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* rtl/kcps_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcps_ctrl: per-tick controller of the sampler
// Edge detection on the keys, start/stop toggle, period selection, blink
// and sample counters, and the millivolt result of a fired sample.
// ----------------------------------------------------------------------------
module kcps_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr,
    input  wire logic [kcps_pkg::PERIOD_W-1:0]  i_cfg_data,
    input  wire logic                           i_step,
    input  wire kcps_pkg::t_item                i_item,
    output kcps_pkg::t_result                   o_result
);
    import kcps_pkg::*;

    localparam int unsigned BLINK_W = 7;
    localparam int unsigned TICK_W  = 16;

    localparam logic [BLINK_W-1:0]  BLINK_LIMIT = 7'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN  = 10'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 10'd600;
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 10'd5;
    localparam logic [PERIOD_W-1:0] PERIOD_P5   = 10'd5;
    localparam logic [PERIOD_W-1:0] PERIOD_P10  = 10'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_P15  = 10'd15;

    logic                 r_synced;
    logic [KEYS_W-1:0]    r_prev;
    logic                 r_latch;
    logic                 r_samp;
    logic                 r_led;
    logic [BLINK_W-1:0]   r_blink;
    logic [TICK_W-1:0]    r_ticks;
    logic [PERIOD_W-1:0]  r_period;

    logic                 n_synced;
    logic [KEYS_W-1:0]    n_prev;
    logic                 n_latch;
    logic                 n_samp;
    logic                 n_led;
    logic [BLINK_W-1:0]   n_blink;
    logic [TICK_W-1:0]    n_ticks;
    logic [PERIOD_W-1:0]  n_period;
    logic                 fire;

    // Period in ticks: p * 100 = p*64 + p*32 + p*4
    function automatic logic [TICK_W-1:0] period_ticks(input logic [PERIOD_W-1:0] p);
        logic [TICK_W-1:0] w;
        begin
            w = TICK_W'(p);
            period_ticks = (w << 6) + (w << 5) + (w << 2);
        end
    endfunction

    // Keep a written period within 1..600
    function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
        begin
            if (p < PERIOD_MIN) begin
                clamp_period = PERIOD_MIN;
            end else if (p > PERIOD_MAX) begin
                clamp_period = PERIOD_MAX;
            end else begin
                clamp_period = p;
            end
        end
    endfunction

    // Divide raw*3300 by 4095: floor by 4096, then one correction step
    function automatic logic [RAW_W-1:0] to_mv(input logic [PROD_W-1:0] prod);
        logic [RAW_W-1:0] q0;
        logic [RAW_W:0]   rem;
        begin
            q0  = prod[PROD_W-1:RAW_W];
            rem = {1'b0, prod[RAW_W-1:0]} + {1'b0, q0};
            to_mv = (rem >= {1'b0, RAW_FULL_SCALE}) ? q0 + 1'b1 : q0;
        end
    endfunction

    // Next state for one tick
    always_comb begin
        logic [KEYS_W-1:0] rise;
        logic [KEYS_W-1:0] fall;
        rise     = i_item.keys & ~r_prev;
        fall     = ~i_item.keys & r_prev;
        n_synced = 1'b1;
        n_prev   = i_item.keys;
        n_latch  = r_latch;
        n_samp   = r_samp;
        n_led    = r_led;
        n_blink  = r_blink;
        n_ticks  = r_ticks;
        n_period = r_period;
        fire     = 1'b0;
        if (r_synced) begin
            if (rise[KEY_TOGGLE]) begin
                n_latch = 1'b1;
            end
            // Toggle sampling on release after a press
            if (fall[KEY_TOGGLE] && n_latch) begin
                n_latch = 1'b0;
                if (r_samp) begin
                    n_samp = 1'b0;
                    n_led  = 1'b0;
                end else begin
                    n_samp  = 1'b1;
                    n_blink = '0;
                    n_ticks = period_ticks(r_period);
                end
            end
            // Period keys, last one wins
            if (rise[KEY_P5]) begin
                n_period = PERIOD_P5;
                n_ticks  = '0;
            end
            if (rise[KEY_P10]) begin
                n_period = PERIOD_P10;
                n_ticks  = '0;
            end
            if (rise[KEY_P15]) begin
                n_period = PERIOD_P15;
                n_ticks  = '0;
            end
            // Advance blink and sample counters
            if (n_samp) begin
                n_blink = n_blink + 1'b1;
                n_ticks = n_ticks + 1'b1;
                if (n_blink >= BLINK_LIMIT) begin
                    n_blink = '0;
                    n_led   = !n_led;
                end
                if (n_ticks >= period_ticks(n_period)) begin
                    n_ticks = '0;
                    fire    = 1'b1;
                end
            end
        end
    end

    // Result of this tick
    always_comb begin
        o_result.sampling_on  = n_samp;
        o_result.blink_led    = n_led;
        o_result.sample_valid = fire;
        o_result.sample_raw   = fire ? i_item.raw : '0;
        o_result.sample_mv    = fire ? to_mv(i_item.prod) : '0;
        o_result.period_now   = n_period;
    end

    // Update state on each tick; a config write takes priority and reloads only the period
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_synced <= 1'b0;
            r_prev   <= '0;
            r_latch  <= 1'b0;
            r_samp   <= 1'b0;
            r_led    <= 1'b0;
            r_blink  <= '0;
            r_ticks  <= '0;
            r_period <= PERIOD_RST;
        end else if (i_cfg_wr) begin
            r_period <= clamp_period(i_cfg_data);
        end else if (i_step) begin
            r_synced <= n_synced;
            r_prev   <= n_prev;
            r_latch  <= n_latch;
            r_samp   <= n_samp;
            r_led    <= n_led;
            r_blink  <= n_blink;
            r_ticks  <= n_ticks;
            r_period <= n_period;
        end
    end

endmodule

`default_nettype wire

/* rtl/kcps_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcps_out_reg: result register of the sampler
// Holds one result beat until the consumer takes it; reloads in the
// same cycle that the held beat leaves.
// ----------------------------------------------------------------------------
module kcps_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire kcps_pkg::t_result   i_result,
    output logic                     o_space,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output kcps_pkg::t_result        o_result
);
    import kcps_pkg::*;

    logic    r_vld;
    t_result r_result;

    // Free when empty or when the held beat is taken now
    assign o_space = !r_vld || i_ready;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_space) begin
            r_vld <= i_load;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_vld;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/key_controlled_periodic_sampler_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_controlled_periodic_sampler_top: key-controlled periodic sampler
// Path: input register holds the tick beat, result register its result.
// Throughput: one tick beat per cycle while result beats are taken; the tick
// controller updates its state in the cycle a beat moves from the input
// register to the result register, unless a config write comes in that cycle.
// Reset: synchronous, active low; clears both registers and all state, and
// loads a 5 s period.
// ----------------------------------------------------------------------------
module key_controlled_periodic_sampler_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Configuration: sample period in seconds
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [9:0]   i_cfg_data,
    // Tick beats
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [0] key_toggle_level, [1] key_p5_level, [2] key_p10_level,
    // [3] key_p15_level, [15:4] adc_reading
    input  wire logic [15:0]  s_axis_tdata,
    // Result beats
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] sampling_on, [1] blink_led, [13:2] sample_raw,
    // [25:14] sample_millivolts, [35:26] period_now_s, [39:36] zero
    output logic [39:0]       m_axis_tdata,
    // [0] sample_valid
    output logic              m_axis_tuser
);
    import kcps_pkg::*;

    logic    in_vld;
    t_item   in_item;
    logic    out_space;
    logic    advance;
    logic    cfg_wr;
    t_result step_result;
    t_result out_result;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Move a beat when the input holds one and the result register is free
    assign advance = in_vld && out_space;

    kcps_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_keys  (s_axis_tdata[3:0]),
        .i_raw   (s_axis_tdata[15:4]),
        .i_take  (advance),
        .o_valid (in_vld),
        .o_item  (in_item)
    );

    kcps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (i_cfg_data),
        .i_step     (advance),
        .i_item     (in_item),
        .o_result   (step_result)
    );

    kcps_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (step_result),
        .o_space  (out_space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    // Pack the result beat
    assign m_axis_tdata = {4'b0000,
                           out_result.period_now,
                           out_result.sample_mv,
                           out_result.sample_raw,
                           out_result.blink_led,
                           out_result.sampling_on};
    assign m_axis_tuser = out_result.sample_valid;

endmodule

`default_nettype wire
